// ===== hw/rtl/rgb_to_hsv_pixel_defines.svh =====
// Assertion macros shared by the RGB to HSV pixel converter RTL.
// Expects clk and rst_n in the scope of each use; no other dependencies.
`ifndef RGB_TO_HSV_PIXEL_DEFINES_SVH
`define RGB_TO_HSV_PIXEL_DEFINES_SVH

`ifndef SYNTHESIS
`define RTHP_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rthp assertion failed");
`define RTHP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rthp assertion failed");
`else
`define RTHP_ASSERT_IMPL(lbl, ante, cons)
`define RTHP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== hw/rtl/rthp_pkg.sv =====
// Types and constants of the RGB to HSV pixel converter.
// Used by every module of the block; no dependencies.
package rthp_pkg;

    localparam int CHAN_W    = 8;
    localparam int DIV_STEPS = 9;
    localparam int QUO_W     = DIV_STEPS;
    localparam int NUM_W     = 18;
    localparam int HUE_W     = 9;
    localparam int PCT_W     = 7;

    localparam logic signed [NUM_W:0] HUE_SLOPE      = 60;
    localparam logic signed [NUM_W:0] HUE_BASE_GREEN = 120;
    localparam logic signed [NUM_W:0] HUE_BASE_BLUE  = 240;
    localparam logic signed [NUM_W:0] HUE_WRAP       = 360;
    localparam logic [NUM_W-1:0]      PCT_SCALE      = 200;
    localparam logic [NUM_W-1:0]      VAL_BIAS       = 255;
    localparam logic [NUM_W-1:0]      UNIT_DEN       = 1;

    typedef struct packed {
        logic [CHAN_W-1:0] red_in;
        logic [CHAN_W-1:0] green_in;
        logic [CHAN_W-1:0] blue_in;
    } rgb_t;

    typedef struct packed {
        logic [HUE_W-1:0] hue_deg;
        logic [PCT_W-1:0] sat_pct;
        logic [PCT_W-1:0] val_pct;
    } hsv_t;

    typedef enum logic [1:0] {
        SECTOR_RED,
        SECTOR_GREEN,
        SECTOR_BLUE
    } sector_t;

    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [NUM_W-1:0] dsh;
        logic [QUO_W-1:0] quo;
    } div_lane_t;

    typedef struct packed {
        div_lane_t        hue;
        div_lane_t        sat;
        logic [PCT_W-1:0] val;
    } cell_word_t;

endpackage

// ===== hw/rtl/rthp_prep.sv =====
// Front end of the converter: channel max/min, sector, value and divider operands.
// Two register stages; depends on rthp_pkg.
module rthp_prep (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                accept,
    input  rthp_pkg::rgb_t      rgb,
    output logic                word_valid,
    output rthp_pkg::cell_word_t word
);
    import rthp_pkg::*;

    logic                     s1_valid_reg;
    logic [CHAN_W-1:0]        s1_max_reg;
    logic [CHAN_W-1:0]        s1_delta_reg;
    logic signed [CHAN_W:0]   s1_diff_reg;
    sector_t                  s1_sector_reg;
    logic                     s2_valid_reg;
    cell_word_t               s2_word_reg;

    logic [CHAN_W-1:0]        max_c;
    logic [CHAN_W-1:0]        min_c;
    logic signed [CHAN_W:0]   diff_c;
    sector_t                  sector_c;

    logic signed [NUM_W:0]    delta_c;
    logic signed [NUM_W:0]    slope_c;
    logic signed [NUM_W:0]    base_c;
    logic signed [NUM_W:0]    num_c;
    logic signed [NUM_W:0]    num2_c;
    logic [NUM_W-1:0]         max_w;
    logic [NUM_W-1:0]         delta_w;
    logic [NUM_W-1:0]         val_half;
    logic [NUM_W-1:0]         val_quo;
    cell_word_t               word_next;

    always_comb
    begin
        max_c = rgb.red_in;
        min_c = rgb.red_in;
        if (rgb.green_in > max_c) max_c = rgb.green_in;
        if (rgb.blue_in > max_c)  max_c = rgb.blue_in;
        if (rgb.green_in < min_c) min_c = rgb.green_in;
        if (rgb.blue_in < min_c)  min_c = rgb.blue_in;
        priority if (rgb.red_in == max_c)
        begin
            sector_c = SECTOR_RED;
            diff_c   = signed'({1'b0, rgb.green_in}) - signed'({1'b0, rgb.blue_in});
        end
        else if (rgb.green_in == max_c)
        begin
            sector_c = SECTOR_GREEN;
            diff_c   = signed'({1'b0, rgb.blue_in}) - signed'({1'b0, rgb.red_in});
        end
        else
        begin
            sector_c = SECTOR_BLUE;
            diff_c   = signed'({1'b0, rgb.red_in}) - signed'({1'b0, rgb.green_in});
        end
    end

    always_comb
    begin
        delta_c = signed'((NUM_W+1)'(s1_delta_reg));
        slope_c = s1_diff_reg * HUE_SLOPE;
        unique case (s1_sector_reg)
            SECTOR_RED:   base_c = '0;
            SECTOR_GREEN: base_c = delta_c * HUE_BASE_GREEN;
            SECTOR_BLUE:  base_c = delta_c * HUE_BASE_BLUE;
            default:      base_c = '0;
        endcase
        num_c = slope_c + base_c;
        if (num_c < 0)
            num_c = num_c + delta_c * HUE_WRAP;
        num2_c  = (num_c <<< 1) + delta_c;
        max_w   = NUM_W'(s1_max_reg);
        delta_w = NUM_W'(s1_delta_reg);

        // divide by 510 as halve, then divide by 255 with shift and add
        val_half = (max_w * PCT_SCALE + VAL_BIAS) >> 1;
        val_quo  = (val_half + UNIT_DEN + (val_half >> CHAN_W)) >> CHAN_W;

        word_next.val     = val_quo[PCT_W-1:0];
        word_next.hue.quo = '0;
        word_next.sat.quo = '0;
        if (s1_delta_reg == '0)
        begin
            word_next.hue.rem = '0;
            word_next.hue.dsh = UNIT_DEN << (QUO_W - 1);
            word_next.sat.rem = '0;
            word_next.sat.dsh = UNIT_DEN << (QUO_W - 1);
        end
        else
        begin
            word_next.hue.rem = num2_c[NUM_W-1:0];
            word_next.hue.dsh = (delta_w << 1) << (QUO_W - 1);
            word_next.sat.rem = delta_w * PCT_SCALE + max_w;
            word_next.sat.dsh = (max_w << 1) << (QUO_W - 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_max_reg    <= max_c;
            s1_delta_reg  <= max_c - min_c;
            s1_diff_reg   <= diff_c;
            s1_sector_reg <= sector_c;
            s2_word_reg   <= word_next;
        end
    end

    assign word_valid = s2_valid_reg;
    assign word       = s2_word_reg;

endmodule

// ===== hw/rtl/rthp_div_cell.sv =====
// One cell of the divider chain: one quotient bit for each of the hue and
// saturation lanes; the value word passes through. Depends on rthp_pkg.
module rthp_div_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  rthp_pkg::cell_word_t in_word,
    output logic                 out_valid,
    output rthp_pkg::cell_word_t out_word
);
    import rthp_pkg::*;

    logic       valid_reg;
    cell_word_t word_reg;
    cell_word_t word_next;

    function automatic div_lane_t div_step(input div_lane_t a);
        div_lane_t r;
        r.dsh = a.dsh >> 1;
        if (a.rem >= a.dsh)
        begin
            r.rem = a.rem - a.dsh;
            r.quo = {a.quo[QUO_W-2:0], 1'b1};
        end
        else
        begin
            r.rem = a.rem;
            r.quo = {a.quo[QUO_W-2:0], 1'b0};
        end
        return r;
    endfunction

    always_comb
    begin
        word_next.hue = div_step(in_word.hue);
        word_next.sat = div_step(in_word.sat);
        word_next.val = in_word.val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

// ===== hw/rtl/rthp_outbuf.sv =====
// Output register with skid stage; drives the pipeline advance enable.
// Depends on rthp_pkg and rgb_to_hsv_pixel_defines.svh.
`include "rgb_to_hsv_pixel_defines.svh"

module rthp_outbuf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pipe_valid,
    input  rthp_pkg::cell_word_t pipe_word,
    input  logic                 hsv_stall,
    output logic                 hsv_valid,
    output rthp_pkg::hsv_t       hsv,
    output logic                 en
);
    import rthp_pkg::*;

    logic  out_valid_reg;
    logic  out_valid_next;
    logic  skid_full_reg;
    logic  skid_full_next;
    hsv_t  out_word_reg;
    hsv_t  skid_word_reg;
    hsv_t  pipe_hsv;
    logic  load_out_pipe;
    logic  load_out_skid;
    logic  load_skid;

    always_comb
    begin
        pipe_hsv.hue_deg = pipe_word.hue.quo[HUE_W-1:0];
        pipe_hsv.sat_pct = pipe_word.sat.quo[PCT_W-1:0];
        pipe_hsv.val_pct = pipe_word.val;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        skid_full_next = skid_full_reg;
        load_out_pipe  = 1'b0;
        load_out_skid  = 1'b0;
        load_skid      = 1'b0;
        priority if (skid_full_reg)
        begin
            if (!hsv_stall)
            begin
                load_out_skid  = 1'b1;
                skid_full_next = 1'b0;
            end
        end
        else if (!out_valid_reg || !hsv_stall)
        begin
            load_out_pipe  = 1'b1;
            out_valid_next = pipe_valid;
        end
        else if (pipe_valid)
        begin
            load_skid      = 1'b1;
            skid_full_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            skid_full_reg <= skid_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out_pipe)
            out_word_reg <= pipe_hsv;
        else if (load_out_skid)
            out_word_reg <= skid_word_reg;
        if (load_skid)
            skid_word_reg <= pipe_hsv;
    end

    assign hsv_valid = out_valid_reg;
    assign hsv       = out_word_reg;
    assign en        = !skid_full_reg;

    `RTHP_ASSERT_IMPL(a_skid_needs_out, skid_full_reg, out_valid_reg)
    `RTHP_ASSERT_NEXT(a_skid_drains, skid_full_reg && !hsv_stall, !skid_full_reg && out_valid_reg)
    `RTHP_ASSERT_IMPL(a_out_ranges, out_valid_reg,
        out_word_reg.hue_deg <= 9'd360 && out_word_reg.sat_pct <= 7'd100
        && out_word_reg.val_pct <= 7'd100)

endmodule

// ===== hw/rtl/rgb_to_hsv_pixel.sv =====
// Top level of the RGB to HSV pixel converter.
// Depends on rthp_pkg, rthp_prep, rthp_div_cell and rthp_outbuf.
//
// Usage:
//   rgb channel: one RGB word, taken at a clock edge where rgb_valid is
//   high and rgb_stall is low. hsv channel: one HSV word per RGB word,
//   in order, delivered while hsv_valid is high and hsv_stall is low.
//   Throughput is one word per clock while rgb_stall is low. The path from the
//   accepting edge to hsv_valid: two front stages (max/min, then divider
//   operands and value), nine divider cells that each resolve one quotient
//   bit of the hue and saturation lanes, and the output register.
//   When hsv_stall holds a valid word, one more word lands in the skid
//   stage, then the whole pipeline holds and rgb_stall rises until the
//   skid stage drains. rgb_stall is a register and does not follow
//   hsv_stall in the same cycle.
//   Reset clears all valid flags; no words are in flight afterwards and
//   the block accepts on the first cycle out of reset.
module rgb_to_hsv_pixel (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            rgb_valid,
    output logic            rgb_stall,
    input  rthp_pkg::rgb_t  rgb,
    output logic            hsv_valid,
    input  logic            hsv_stall,
    output rthp_pkg::hsv_t  hsv
);
    import rthp_pkg::*;

    logic       en;
    logic       accept;
    logic       chain_valid [DIV_STEPS+1];
    cell_word_t chain_word  [DIV_STEPS+1];

    assign rgb_stall = !en;
    assign accept    = rgb_valid && en;

    rthp_prep u_prep (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .accept     (accept),
        .rgb        (rgb),
        .word_valid (chain_valid[0]),
        .word       (chain_word[0])
    );

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_cell
        rthp_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (chain_valid[i]),
            .in_word   (chain_word[i]),
            .out_valid (chain_valid[i+1]),
            .out_word  (chain_word[i+1])
        );
    end

    rthp_outbuf u_outbuf (
        .clk        (clk),
        .rst_n      (rst_n),
        .pipe_valid (chain_valid[DIV_STEPS]),
        .pipe_word  (chain_word[DIV_STEPS]),
        .hsv_stall  (hsv_stall),
        .hsv_valid  (hsv_valid),
        .hsv        (hsv),
        .en         (en)
    );

endmodule

// ===== sim/rgb_to_hsv_pixel_checker.sv =====
// Checker for the RGB to HSV pixel converter: watches both channels, predicts each HSV word
// from the accepted RGB word and compares in order. Depends on rthp_pkg only.
`timescale 1ns / 100ps

module rgb_to_hsv_pixel_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           rgb_valid,
    input  logic           rgb_stall,
    input  rthp_pkg::rgb_t rgb,
    input  logic           hsv_valid,
    input  logic           hsv_stall,
    input  rthp_pkg::hsv_t hsv,
    output int             fail_count,
    output int             pending
);
    import rthp_pkg::*;

    hsv_t hsv_due[$];
    hsv_t want;
    int   mismatches = 0;

    assign fail_count = mismatches;

    function automatic hsv_t hsv_of_rgb(input rgb_t px);
        int      r;
        int      g;
        int      b;
        int      hi;
        int      lo;
        int      spread;
        int      diff;
        int      base;
        int      num;
        sector_t sect;
        hsv_t    res;
        r = px.red_in;
        g = px.green_in;
        b = px.blue_in;
        hi = r;
        lo = r;
        if (g > hi) hi = g;
        if (b > hi) hi = b;
        if (g < lo) lo = g;
        if (b < lo) lo = b;
        spread = hi - lo;
        res.val_pct = PCT_W'((200 * hi + 255) / 510);
        if (spread == 0)
        begin
            res.hue_deg = '0;
            res.sat_pct = '0;
        end
        else
        begin
            res.sat_pct = PCT_W'((200 * spread + hi) / (2 * hi));
            if (r == hi)
                sect = SECTOR_RED;
            else if (g == hi)
                sect = SECTOR_GREEN;
            else
                sect = SECTOR_BLUE;
            case (sect)
                SECTOR_RED:
                begin
                    diff = g - b;
                    base = 0;
                end
                SECTOR_GREEN:
                begin
                    diff = b - r;
                    base = 120;
                end
                default:
                begin
                    diff = r - g;
                    base = 240;
                end
            endcase
            num = 60 * diff + base * spread;
            if (num < 0)
                num += 360 * spread;
            res.hue_deg = HUE_W'((2 * num + spread) / (2 * spread));
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        if (mismatches < 100)
            $display("%0t %s: got %0d, want %0d", $realtime, what, got, exp_val);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hsv_due.delete();
            pending <= 0;
        end
        else
        begin
            if (hsv_valid && !hsv_stall)
            begin
                if (hsv_due.size() == 0)
                begin
                    report_mismatch("unexpected word, hue", hsv.hue_deg, -1);
                end
                else
                begin
                    want = hsv_due.pop_front();
                    if (hsv.hue_deg !== want.hue_deg)
                        report_mismatch("hue_deg", hsv.hue_deg, want.hue_deg);
                    if (hsv.sat_pct !== want.sat_pct)
                        report_mismatch("sat_pct", hsv.sat_pct, want.sat_pct);
                    if (hsv.val_pct !== want.val_pct)
                        report_mismatch("val_pct", hsv.val_pct, want.val_pct);
                end
            end
            if (rgb_valid && !rgb_stall)
                hsv_due.push_back(hsv_of_rgb(rgb));
            pending <= hsv_due.size();
        end
    end

endmodule

// ===== sim/testbench.sv =====
// Top of the RGB to HSV pixel converter testbench: clock, reset, RGB stimulus, HSV stalls
// and the verdict. Depends on rthp_pkg, rgb_to_hsv_pixel and rgb_to_hsv_pixel_checker.
`timescale 1ns / 100ps

module testbench;
    import rthp_pkg::*;

    localparam int   N_RANDOM = 1300;
    localparam int   N_DIRECT = 20;
    localparam rgb_t DIRECT_PIXELS [N_DIRECT] = '{
        {8'd0,   8'd0,   8'd0},
        {8'd255, 8'd255, 8'd255},
        {8'd128, 8'd128, 8'd128},
        {8'd1,   8'd1,   8'd1},
        {8'd255, 8'd0,   8'd0},
        {8'd0,   8'd255, 8'd0},
        {8'd0,   8'd0,   8'd255},
        {8'd255, 8'd255, 8'd0},
        {8'd0,   8'd255, 8'd255},
        {8'd255, 8'd0,   8'd255},
        {8'd255, 8'd0,   8'd1},
        {8'd1,   8'd0,   8'd0},
        {8'd0,   8'd1,   8'd0},
        {8'd0,   8'd0,   8'd1},
        {8'd255, 8'd254, 8'd0},
        {8'd200, 8'd100, 8'd150},
        {8'd254, 8'd1,   8'd2},
        {8'd127, 8'd255, 8'd128},
        {8'd85,  8'd170, 8'd255},
        {8'd255, 8'd128, 8'd0}
    };

    logic clk;
    logic rst_n;
    logic rgb_valid;
    logic rgb_stall;
    rgb_t rgb;
    logic hsv_valid;
    logic hsv_stall;
    hsv_t hsv;
    int   fail_count;
    int   pending;

    rgb_to_hsv_pixel u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .rgb_valid (rgb_valid),
        .rgb_stall (rgb_stall),
        .rgb       (rgb),
        .hsv_valid (hsv_valid),
        .hsv_stall (hsv_stall),
        .hsv       (hsv)
    );

    rgb_to_hsv_pixel_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .rgb_valid  (rgb_valid),
        .rgb_stall  (rgb_stall),
        .rgb        (rgb),
        .hsv_valid  (hsv_valid),
        .hsv_stall  (hsv_stall),
        .hsv        (hsv),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int draw_gap(input int idx);
        if ((idx / 100) % 4 == 1)
            return 0;
        return $urandom_range(0, 6);
    endfunction

    function automatic logic [7:0] edge_chan();
        case ($urandom_range(0, 4))
            0:       return 8'd0;
            1:       return 8'd1;
            2:       return 8'd254;
            3:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic rgb_t rand_pixel();
        rgb_t       px;
        logic [7:0] hi;
        logic [7:0] lo;
        px = rgb_t'($urandom);
        case ($urandom_range(0, 7))
            4:
            begin
                px.green_in = px.red_in;
                px.blue_in  = px.red_in;
            end
            5:
            begin
                hi = 8'($urandom_range(1, 255));
                lo = 8'($urandom_range(0, hi - 1));
                case ($urandom_range(0, 2))
                    0:       px = {hi, hi, lo};
                    1:       px = {lo, hi, hi};
                    default: px = {hi, lo, hi};
                endcase
            end
            6:
            begin
                px.red_in   = edge_chan();
                px.green_in = edge_chan();
                px.blue_in  = edge_chan();
            end
            7:
            begin
                hi = 8'($urandom_range(128, 255));
                lo = 8'($urandom_range(0, 3));
                px = {hi, lo, 8'(lo + $urandom_range(1, 2))};
            end
            default:
            begin
            end
        endcase
        return px;
    endfunction

    task automatic send_pixel(input rgb_t px, input int gap);
        if (gap > 0)
        begin
            rgb_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rgb_valid <= 1'b1;
        rgb       <= px;
        @(posedge clk);
        while (rgb_stall) @(posedge clk);
    endtask

    task automatic drain_all();
        rgb_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial
    begin : drain_side
        int words;
        int hold_n;
        words     = 0;
        hsv_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (words == 300 || words == 900)
                hold_n = 120;
            else if ((words / 100) % 4 == 3)
                hold_n = 0;
            else
                hold_n = $urandom_range(0, 6);
            if (hold_n > 0)
            begin
                hsv_stall <= 1'b1;
                repeat (hold_n) @(posedge clk);
                hsv_stall <= 1'b0;
            end
            do @(posedge clk); while (!hsv_valid);
            words++;
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        rgb_valid = 1'b0;
        rgb       = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < N_DIRECT; i++)
            send_pixel(DIRECT_PIXELS[i], $urandom_range(0, 6));
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == 650)
                drain_all();
            send_pixel(rand_pixel(), draw_gap(i));
        end
        drain_all();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("rgb_to_hsv_pixel: match");
        else
            $display("rgb_to_hsv_pixel: mismatch");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("rgb_to_hsv_pixel: mismatch");
        $finish;
    end

endmodule
